// ----- rtl/sfcs_pkg.sv -----
// Shared types and constants for the SPI flash command sequencer.
package sfcs_pkg;

  localparam int unsigned BufferWordsDefault = 16;
  localparam int unsigned SelectCountDefault = 3;
  localparam int unsigned CtrlCount = 11;

  typedef enum logic [1:0] {
    OP_READ  = 2'd0,
    OP_WRITE = 2'd1,
    OP_MISO  = 2'd2,
    OP_NONE  = 2'd3
  } op_t;

  typedef enum logic [1:0] {
    KIND_READ = 2'd0,
    KIND_BYTE = 2'd1,
    KIND_DONE = 2'd2,
    KIND_NONE = 2'd3
  } kind_t;

  // control register slots (bus index minus one)
  localparam logic [3:0] RG_ADDR      = 4'd0;
  localparam logic [3:0] RG_STATUS    = 4'd2;
  localparam logic [3:0] RG_USER      = 4'd5;
  localparam logic [3:0] RG_USER1     = 4'd6;
  localparam logic [3:0] RG_USER2     = 4'd7;
  localparam logic [3:0] RG_MOSI_DLEN = 4'd8;
  localparam logic [3:0] RG_MISO_DLEN = 4'd9;
  localparam logic [3:0] RG_PIN       = 4'd10;

  localparam logic [4:0] IDX_COMMAND  = 5'd0;
  localparam logic [4:0] IDX_LAST_REG = 5'd11;

  // command register bits
  localparam logic [31:0] CB_READ = 32'h8000_0000;
  localparam logic [31:0] CB_WREN = 32'h4000_0000;
  localparam logic [31:0] CB_WRDI = 32'h2000_0000;
  localparam logic [31:0] CB_RDID = 32'h1000_0000;
  localparam logic [31:0] CB_RDSR = 32'h0800_0000;
  localparam logic [31:0] CB_WRSR = 32'h0400_0000;
  localparam logic [31:0] CB_PP   = 32'h0200_0000;
  localparam logic [31:0] CB_SE   = 32'h0100_0000;
  localparam logic [31:0] CB_BE   = 32'h0080_0000;
  localparam logic [31:0] CB_CE   = 32'h0040_0000;
  localparam logic [31:0] CB_DP   = 32'h0020_0000;
  localparam logic [31:0] CB_RES  = 32'h0010_0000;
  localparam logic [31:0] CB_USER = 32'h0004_0000;

  // flash opcodes
  localparam logic [7:0] FL_RES  = 8'hab;
  localparam logic [7:0] FL_DP   = 8'hb9;
  localparam logic [7:0] FL_CE   = 8'h60;
  localparam logic [7:0] FL_BE   = 8'hd8;
  localparam logic [7:0] FL_SE   = 8'h20;
  localparam logic [7:0] FL_PP   = 8'h02;
  localparam logic [7:0] FL_WRSR = 8'h01;
  localparam logic [7:0] FL_RDSR = 8'h05;
  localparam logic [7:0] FL_RDID = 8'h9f;
  localparam logic [7:0] FL_WRDI = 8'h04;
  localparam logic [7:0] FL_WREN = 8'h06;
  localparam logic [7:0] FL_READ = 8'h03;

  typedef struct packed {
    logic        is_read;
    logic        is_write;
    logic        is_cmd;
    logic        is_miso;
    logic [4:0]  reg_index;
    logic [31:0] write_data;
    logic [7:0]  miso_byte;
  } item_t;

  function automatic logic [31:0] swap32(input logic [31:0] v);
    swap32 = {v[7:0], v[15:8], v[23:16], v[31:24]};
  endfunction

endpackage

// ----- rtl/sfcs_front.sv -----
// Front end: accepts bus and MISO transactions, classifies them, queues them.
module sfcs_front (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_stall,
  input  logic [1:0]        op,
  input  logic [4:0]        reg_index,
  input  logic [31:0]       write_data,
  input  logic [7:0]        miso_byte,
  output logic              q_valid,
  output sfcs_pkg::item_t   q_item,
  input  logic              q_pop
);
  import sfcs_pkg::*;

  item_t      slot [2];
  logic       rd_ptr;
  logic       wr_ptr;
  logic [1:0] count;
  item_t      cls;
  logic       push;

  always_comb begin
    cls.is_read    = (op == OP_READ);
    cls.is_write   = (op == OP_WRITE) && (reg_index != IDX_COMMAND);
    cls.is_cmd     = (op == OP_WRITE) && (reg_index == IDX_COMMAND);
    cls.is_miso    = (op == OP_MISO);
    cls.reg_index  = reg_index;
    cls.write_data = write_data;
    cls.miso_byte  = miso_byte;
  end

  assign in_stall = (count == 2'd2);
  // op code three is accepted and dropped
  assign push     = in_valid && !in_stall && (op != OP_NONE);
  assign q_valid  = (count != 2'd0);
  assign q_item   = slot[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      rd_ptr <= 1'b0;
      wr_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (push) wr_ptr <= ~wr_ptr;
      if (q_pop) rd_ptr <= ~rd_ptr;
      count <= count + 2'(push) - 2'(q_pop);
    end
  end

  always_ff @(posedge clk) begin
    if (push) slot[wr_ptr] <= cls;
  end

endmodule

// ----- rtl/sfcs_back.sv -----
// Back end: register file, data buffer and SPI byte sequencing.
module sfcs_back #(
  parameter int unsigned BUFFER_WORDS = sfcs_pkg::BufferWordsDefault,
  parameter int unsigned SELECT_COUNT = sfcs_pkg::SelectCountDefault
) (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    q_valid,
  input  sfcs_pkg::item_t         q_item,
  output logic                    q_pop,
  output logic                    out_valid,
  input  logic                    out_stall,
  output logic [1:0]              kind,
  output logic [31:0]             read_data,
  output logic [7:0]              mosi_byte,
  output logic [SELECT_COUNT-1:0] cs_lines
);
  import sfcs_pkg::*;

  localparam int unsigned BufBytes = BUFFER_WORDS * 4;
  localparam int unsigned LW  = $clog2(BufBytes + 1);
  localparam int unsigned CW  = $clog2(BufBytes + 7);
  localparam int unsigned WIW = (BUFFER_WORDS > 1) ? $clog2(BUFFER_WORDS) : 1;
  localparam logic [LW-1:0] BufBytesL = LW'(BufBytes);
  localparam logic [SELECT_COUNT-1:0] SelAll = '1;

  typedef struct packed {
    logic [15:0]   cmd;
    logic [1:0]    cmd_n;
    logic [31:0]   addr;
    logic [2:0]    addr_n;
    logic [LW-1:0] tx_n;
    logic [LW-1:0] rx_n;
    logic          to_status;
  } xfer_t;

  logic [31:0]             ctrl [CtrlCount];
  logic [31:0]             dbuf [BUFFER_WORDS];
  logic                    busy;
  logic [CW-1:0]           cnt;
  xfer_t                   tr;
  logic [SELECT_COUNT-1:0] cs;

  logic [31:0]             ctrl_next [CtrlCount];
  logic [31:0]             dbuf_next [BUFFER_WORDS];
  logic                    busy_next;
  logic [CW-1:0]           cnt_next;
  xfer_t                   tr_next;
  logic [SELECT_COUNT-1:0] cs_next;

  logic        go;
  logic        emit;
  kind_t       e_kind;
  logic [31:0] e_data;
  logic [7:0]  e_mosi;

  function automatic logic [LW-1:0] len_bytes(input logic [31:0] b);
    logic [29:0] n;
    n = {1'b0, b[31:3]} + 30'd1;
    len_bytes = (n > 30'(BufBytes)) ? BufBytesL : LW'(n);
  endfunction

  assign go    = q_valid && (!out_valid || !out_stall);
  assign q_pop = go;

  always_comb begin
    xfer_t         t;
    logic          ok;
    logic [2:0]    an;
    logic [3:0]    an_raw;
    logic [31:0]   a;
    logic [31:0]   norm;
    logic [CW-1:0] pre;
    logic [CW-1:0] k;
    logic [CW-1:0] p;
    logic [CW-1:0] total;
    logic [LW-1:0] dmax;
    logic [WIW-1:0] wi;
    logic [4:0]    rel;
    logic          adv;

    ctrl_next = ctrl;
    dbuf_next = dbuf;
    busy_next = busy;
    cnt_next  = cnt;
    tr_next   = tr;
    cs_next   = cs;
    emit      = 1'b0;
    e_kind    = KIND_READ;
    e_data    = '0;
    e_mosi    = '0;
    adv       = 1'b0;
    t         = '0;
    ok        = 1'b1;
    a         = ctrl[RG_ADDR];
    an_raw    = 4'({1'b0, ctrl[RG_USER1][31:29]}) + 4'd1;
    an        = (an_raw > 4'd4) ? 3'd4 : an_raw[2:0];
    norm      = swap32(a) >> (6'd32 - {an, 3'b000});
    rel       = q_item.reg_index - 5'd16;
    wi        = WIW'(rel);
    k         = '0;
    pre       = '0;
    p         = '0;
    total     = '0;
    dmax      = '0;

    if (go) begin
      if (q_item.is_read) begin
        emit = 1'b1;
        if (q_item.reg_index != IDX_COMMAND && q_item.reg_index <= IDX_LAST_REG)
          e_data = ctrl[4'(q_item.reg_index - 5'd1)];
        else if (q_item.reg_index[4] && 32'(rel) < BUFFER_WORDS)
          e_data = dbuf[wi];
      end else if (q_item.is_write) begin
        if (q_item.reg_index <= IDX_LAST_REG)
          ctrl_next[4'(q_item.reg_index - 5'd1)] = q_item.write_data;
        else if (q_item.reg_index[4] && 32'(rel) < BUFFER_WORDS)
          dbuf_next[wi] = q_item.write_data;
      end else if (q_item.is_cmd) begin
        t.cmd_n = 2'd1;
        unique case (q_item.write_data)
          CB_READ: begin
            t.cmd = {8'd0, FL_READ}; t.addr_n = an; t.addr = norm;
            t.rx_n = len_bytes(ctrl[RG_MISO_DLEN]);
          end
          CB_WREN: t.cmd = {8'd0, FL_WREN};
          CB_WRDI: t.cmd = {8'd0, FL_WRDI};
          CB_RDID: begin t.cmd = {8'd0, FL_RDID}; t.rx_n = LW'(3); end
          CB_RDSR: begin
            t.cmd = {8'd0, FL_RDSR}; t.rx_n = LW'(1); t.to_status = 1'b1;
          end
          CB_WRSR: begin
            t.cmd = {8'd0, FL_WRSR}; t.tx_n = LW'(1); t.to_status = 1'b1;
          end
          CB_PP: begin
            t.cmd = {8'd0, FL_PP}; t.addr_n = an; t.addr = swap32(a) >> 8;
            t.tx_n = (32'(a[31:24]) > BufBytes) ? BufBytesL : LW'(a[31:24]);
          end
          CB_SE: begin t.cmd = {8'd0, FL_SE}; t.addr_n = an; t.addr = norm; end
          CB_BE: begin t.cmd = {8'd0, FL_BE}; t.addr_n = an; t.addr = norm; end
          CB_CE:  t.cmd = {8'd0, FL_CE};
          CB_DP:  t.cmd = {8'd0, FL_DP};
          CB_RES: begin t.cmd = {8'd0, FL_RES}; t.rx_n = LW'(3); end
          CB_USER: begin
            if (ctrl[RG_USER][31] || ctrl[RG_USER2][31:28] != 4'd0) begin
              t.cmd   = ctrl[RG_USER2][15:0];
              t.cmd_n = ctrl[RG_USER2][31] ? 2'd2 : 2'd1;
            end else begin
              t.cmd_n = 2'd0;
            end
            if (ctrl[RG_USER][30]) begin
              t.addr_n = an; t.addr = swap32(a);
            end
            if (ctrl[RG_USER][27]) t.tx_n = len_bytes(ctrl[RG_MOSI_DLEN]);
            if (ctrl[RG_USER][28]) t.rx_n = len_bytes(ctrl[RG_MISO_DLEN]);
          end
          default: ok = 1'b0;
        endcase
        if (ok && !busy) begin
          tr_next   = t;
          cnt_next  = '0;
          cs_next   = ctrl[RG_PIN][SELECT_COUNT-1:0];
          busy_next = 1'b1;
          adv       = 1'b1;
        end
      end else if (q_item.is_miso && busy) begin
        pre = CW'(tr.cmd_n) + CW'(tr.addr_n);
        k   = cnt - pre;
        if (cnt >= pre && k < CW'(tr.rx_n)) begin
          if (tr.to_status) begin
            if (k < CW'(4))
              ctrl_next[RG_STATUS][{k[1:0], 3'b000} +: 8] = q_item.miso_byte;
          end else if (k < CW'(BufBytes)) begin
            dbuf_next[WIW'(k >> 2)][{k[1:0], 3'b000} +: 8] = q_item.miso_byte;
          end
        end
        cnt_next = cnt + CW'(1);
        adv      = 1'b1;
      end
    end

    if (adv) begin
      emit  = 1'b1;
      dmax  = (tr_next.tx_n > tr_next.rx_n) ? tr_next.tx_n : tr_next.rx_n;
      total = CW'(tr_next.cmd_n) + CW'(tr_next.addr_n) + CW'(dmax);
      if (cnt_next >= total) begin
        busy_next = 1'b0;
        cnt_next  = '0;
        cs_next   = SelAll;
        e_kind    = KIND_DONE;
      end else begin
        e_kind = KIND_BYTE;
        p      = cnt_next;
        if (p < CW'(tr_next.cmd_n)) begin
          e_mosi = p[0] ? tr_next.cmd[15:8] : tr_next.cmd[7:0];
        end else begin
          p = p - CW'(tr_next.cmd_n);
          if (p < CW'(tr_next.addr_n)) begin
            e_mosi = tr_next.addr[{p[1:0], 3'b000} +: 8];
          end else begin
            p = p - CW'(tr_next.addr_n);
            if (p < CW'(tr_next.tx_n)) begin
              if (tr_next.to_status) begin
                if (p < CW'(4)) e_mosi = ctrl_next[RG_STATUS][{p[1:0], 3'b000} +: 8];
              end else if (p < CW'(BufBytes)) begin
                e_mosi = dbuf_next[WIW'(p >> 2)][{p[1:0], 3'b000} +: 8];
              end
            end
          end
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < CtrlCount; i++) begin
        if (i == int'(RG_PIN)) ctrl[i] <= 32'd6;
        else if (i == int'(RG_USER1)) ctrl[i] <= (32'd23 << 26) | 32'd7;
        else ctrl[i] <= '0;
      end
      for (int i = 0; i < BUFFER_WORDS; i++) dbuf[i] <= '0;
      busy      <= 1'b0;
      cnt       <= '0;
      tr        <= '0;
      cs        <= SelAll;
      out_valid <= 1'b0;
    end else begin
      ctrl <= ctrl_next;
      dbuf <= dbuf_next;
      busy <= busy_next;
      cnt  <= cnt_next;
      tr   <= tr_next;
      cs   <= cs_next;
      if (go && emit) out_valid <= 1'b1;
      else if (!out_stall) out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (go && emit) begin
      kind      <= e_kind;
      read_data <= e_data;
      mosi_byte <= e_mosi;
      cs_lines  <= cs_next;
    end
  end

endmodule

// ----- rtl/spi_flash_command_sequencer_unit.sv -----
// Top level of the SPI flash command sequencer.
// An accepted transaction passes the queue slot and the output register.
// Throughput: one transaction per cycle while the output is not stalled.
// A two-entry queue between front and back lets either side stall on its own.
// Reset (synchronous, active high) clears the queue, registers and data buffer;
// pin resets to 6 and user1 to bitlen 23/7, selects go high.
module spi_flash_command_sequencer_unit #(
  parameter int unsigned BUFFER_WORDS = sfcs_pkg::BufferWordsDefault,
  parameter int unsigned SELECT_COUNT = sfcs_pkg::SelectCountDefault
) (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    in_valid,
  output logic                    in_stall,
  input  logic [1:0]              op,
  input  logic [4:0]              reg_index,
  input  logic [31:0]             write_data,
  input  logic [7:0]              miso_byte,
  output logic                    out_valid,
  input  logic                    out_stall,
  output logic [1:0]              kind,
  output logic [31:0]             read_data,
  output logic [7:0]              mosi_byte,
  output logic [SELECT_COUNT-1:0] cs_lines
);
  import sfcs_pkg::*;

  logic  q_valid;
  logic  q_pop;
  item_t q_item;

  sfcs_front u_front (
    .clk, .rst, .in_valid, .in_stall, .op, .reg_index, .write_data, .miso_byte,
    .q_valid, .q_item, .q_pop
  );

  sfcs_back #(.BUFFER_WORDS(BUFFER_WORDS), .SELECT_COUNT(SELECT_COUNT)) u_back (
    .clk, .rst, .q_valid, .q_item, .q_pop,
    .out_valid, .out_stall, .kind, .read_data, .mosi_byte, .cs_lines
  );

  a_done_cs_high: assert property (@(posedge clk) disable iff (rst)
    out_valid && kind == KIND_DONE |-> cs_lines == '1)
    else $error("done result with a select still low");

  a_mosi_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && kind != KIND_BYTE |-> mosi_byte == 8'd0)
    else $error("mosi byte set on a non-byte result");

  a_rdata_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && kind != KIND_READ |-> read_data == 32'd0)
    else $error("read data set on a non-read result");

  a_pop_slot: assert property (@(posedge clk) disable iff (rst)
    q_pop |-> q_valid && !(out_valid && out_stall))
    else $error("queue popped while output slot blocked");

endmodule

// ----- bench/tb_spi_flash_command_sequencer_unit.sv -----
// Self-checking testbench for the SPI flash command sequencer top level.
`timescale 1ns / 1ps

module tb_spi_flash_command_sequencer_unit;
  import sfcs_pkg::*;

  localparam int unsigned BufWords = BufferWordsDefault;
  localparam int unsigned BufBytes = BufWords * 4;
  localparam logic [2:0] SelMask = 3'b111;
  localparam int WatchLimit = 4000;

  typedef enum logic [1:0] {
    PH_IDLE = 2'd0,
    PH_CMD  = 2'd1,
    PH_ADDR = 2'd2,
    PH_DATA = 2'd3
  } phase_t;

  typedef struct packed {
    logic [1:0]  kind;
    logic [31:0] rdata;
    logic [7:0]  mosi;
    logic [2:0]  cs;
  } flash_result_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic [1:0]  op = OP_NONE;
  logic [4:0]  reg_index = '0;
  logic [31:0] write_data = '0;
  logic [7:0]  miso_byte = '0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic [1:0]  kind;
  logic [31:0] read_data;
  logic [7:0]  mosi_byte;
  logic [2:0]  cs_lines;

  spi_flash_command_sequencer_unit u_dut (
    .clk(clk), .rst(rst), .in_valid(in_valid), .in_stall(in_stall), .op(op),
    .reg_index(reg_index), .write_data(write_data), .miso_byte(miso_byte),
    .out_valid(out_valid), .out_stall(out_stall), .kind(kind),
    .read_data(read_data), .mosi_byte(mosi_byte), .cs_lines(cs_lines)
  );

  always #6 clk = ~clk;

  // predictor state
  logic [31:0] ctl_regs [CtrlCount];
  logic [31:0] buf_words [BufWords];
  phase_t      cur_phase;
  int unsigned xfer_pos;
  logic [31:0] x_cmd, x_addr;
  int unsigned x_cmd_n, x_addr_n, x_tx_n, x_rx_n;
  bit          x_status;
  logic [2:0]  sel_level;

  flash_result_t expected_results[$];
  int          mismatches = 0;
  int          send_idle_pct = 0;
  int          recv_idle_pct = 0;
  int          hold_cycles = 0;
  int          quiet_cycles = 0;

  function automatic logic [31:0] byte_swap(logic [31:0] v);
    return {v[7:0], v[15:8], v[23:16], v[31:24]};
  endfunction

  function automatic int unsigned bitlen_bytes(logic [31:0] b, int unsigned lim);
    longint unsigned n;
    n = (longint'(b) + 8) / 8;
    return (n > lim) ? lim : int'(n);
  endfunction

  function automatic logic [7:0] data_byte_at(int unsigned k);
    if (x_status) return (k < 4) ? ctl_regs[RG_STATUS][8*k +: 8] : 8'h00;
    if (k >= BufBytes) return 8'h00;
    return buf_words[k >> 2][8*(k & 3) +: 8];
  endfunction

  task automatic store_rx_byte(int unsigned k, logic [7:0] b);
    if (x_status) begin
      if (k < 4) ctl_regs[RG_STATUS][8*k +: 8] = b;
    end else if (k < BufBytes) begin
      buf_words[k >> 2][8*(k & 3) +: 8] = b;
    end
  endtask

  function automatic logic [7:0] next_tx_byte();
    int unsigned p;
    p = xfer_pos;
    if (p < x_cmd_n) begin
      cur_phase = PH_CMD;
      return x_cmd[8*p +: 8];
    end
    p -= x_cmd_n;
    if (p < x_addr_n) begin
      cur_phase = PH_ADDR;
      return x_addr[8*p +: 8];
    end
    p -= x_addr_n;
    cur_phase = PH_DATA;
    return (p < x_tx_n) ? data_byte_at(p) : 8'h00;
  endfunction

  task automatic push_step();
    flash_result_t r;
    int unsigned dn;
    dn = (x_tx_n > x_rx_n) ? x_tx_n : x_rx_n;
    r = '0;
    if (xfer_pos >= x_cmd_n + x_addr_n + dn) begin
      cur_phase = PH_IDLE;
      xfer_pos = 0;
      sel_level = SelMask;
      r.kind = KIND_DONE;
    end else begin
      r.kind = KIND_BYTE;
      r.mosi = next_tx_byte();
    end
    r.cs = sel_level;
    expected_results.push_back(r);
  endtask

  task automatic start_flash_cmd(logic [31:0] v);
    logic [31:0] a, usr, usr2;
    int unsigned an;
    logic [31:0] norm;
    bit ok;
    a = ctl_regs[RG_ADDR];
    usr = ctl_regs[RG_USER];
    usr2 = ctl_regs[RG_USER2];
    an = bitlen_bytes(ctl_regs[RG_USER1] >> 26, 4);
    norm = byte_swap(a) >> (32 - 8 * an);
    ok = 1;
    if (cur_phase != PH_IDLE) return;
    x_cmd = 0; x_addr = 0; x_cmd_n = 1; x_addr_n = 0; x_tx_n = 0; x_rx_n = 0;
    x_status = 0;
    case (v)
      CB_READ: begin
        x_cmd = FL_READ; x_addr_n = an; x_addr = norm;
        x_rx_n = bitlen_bytes(ctl_regs[RG_MISO_DLEN], BufBytes);
      end
      CB_WREN: x_cmd = FL_WREN;
      CB_WRDI: x_cmd = FL_WRDI;
      CB_RDID: begin x_cmd = FL_RDID; x_rx_n = 3; end
      CB_RDSR: begin x_cmd = FL_RDSR; x_rx_n = 1; x_status = 1; end
      CB_WRSR: begin x_cmd = FL_WRSR; x_tx_n = 1; x_status = 1; end
      CB_PP: begin
        x_cmd = FL_PP; x_addr_n = an; x_addr = byte_swap(a) >> 8;
        x_tx_n = (a[31:24] > BufBytes) ? BufBytes : a[31:24];
      end
      CB_SE: begin x_cmd = FL_SE; x_addr_n = an; x_addr = norm; end
      CB_BE: begin x_cmd = FL_BE; x_addr_n = an; x_addr = norm; end
      CB_CE: x_cmd = FL_CE;
      CB_DP: x_cmd = FL_DP;
      CB_RES: begin x_cmd = FL_RES; x_rx_n = 3; end
      CB_USER: begin
        if (usr[31] || usr2[31:28] != 0) begin
          x_cmd = usr2[15:0];
          x_cmd_n = bitlen_bytes(usr2 >> 28, 2);
        end else begin
          x_cmd_n = 0;
        end
        if (usr[30]) begin x_addr_n = an; x_addr = byte_swap(a); end
        if (usr[27]) x_tx_n = bitlen_bytes(ctl_regs[RG_MOSI_DLEN], BufBytes);
        if (usr[28]) x_rx_n = bitlen_bytes(ctl_regs[RG_MISO_DLEN], BufBytes);
      end
      default: ok = 0;
    endcase
    if (!ok) return;
    xfer_pos = 0;
    sel_level = ctl_regs[RG_PIN][2:0];
    push_step();
  endtask

  task automatic predict_item(logic [1:0] o, logic [4:0] idx, logic [31:0] wd,
                              logic [7:0] mb);
    flash_result_t r;
    int unsigned pre;
    r = '0;
    case (o)
      OP_READ: begin
        if (idx >= 1 && idx <= IDX_LAST_REG) r.rdata = ctl_regs[idx - 1];
        else if (idx >= 16 && idx - 16 < BufWords) r.rdata = buf_words[idx - 16];
        r.kind = KIND_READ;
        r.cs = sel_level;
        expected_results.push_back(r);
      end
      OP_WRITE: begin
        if (idx == IDX_COMMAND) start_flash_cmd(wd);
        else if (idx <= IDX_LAST_REG) ctl_regs[idx - 1] = wd;
        else if (idx >= 16 && idx - 16 < BufWords) buf_words[idx - 16] = wd;
      end
      OP_MISO: begin
        if (cur_phase != PH_IDLE) begin
          pre = x_cmd_n + x_addr_n;
          if (xfer_pos >= pre && xfer_pos - pre < x_rx_n) store_rx_byte(xfer_pos - pre, mb);
          xfer_pos++;
          push_step();
        end
      end
      default: ;
    endcase
  endtask

  task automatic reset_model();
    foreach (ctl_regs[i]) ctl_regs[i] = '0;
    foreach (buf_words[i]) buf_words[i] = '0;
    ctl_regs[RG_PIN] = 32'd6;
    ctl_regs[RG_USER1] = (32'd23 << 26) | 32'd7;
    cur_phase = PH_IDLE;
    xfer_pos = 0;
    x_cmd_n = 0; x_addr_n = 0; x_tx_n = 0; x_rx_n = 0; x_status = 0;
    sel_level = SelMask;
  endtask

  // one transaction on the input channel; valid stays up into the next one
  task automatic send_item(logic [1:0] o, logic [4:0] idx, logic [31:0] wd,
                           logic [7:0] mb);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    op <= o;
    reg_index <= idx;
    write_data <= wd;
    miso_byte <= mb;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    predict_item(o, idx, wd, mb);
    @(negedge clk);
  endtask

  task automatic bus_write(logic [4:0] idx, logic [31:0] wd);
    send_item(OP_WRITE, idx, wd, 8'($urandom));
  endtask

  // answer every outstanding byte until the transaction closes
  task automatic finish_xfer();
    while (cur_phase != PH_IDLE)
      send_item(OP_MISO, 5'($urandom), $urandom, 8'($urandom));
  endtask

  task automatic wait_drain();
    in_valid <= 1'b0;
    while (expected_results.size() != 0) @(negedge clk);
    repeat (4) @(negedge clk);
  endtask

  task automatic test_directed();
    logic [31:0] cmds [13];
    cmds = '{CB_READ, CB_WREN, CB_WRDI, CB_RDID, CB_RDSR, CB_WRSR, CB_PP,
             CB_SE, CB_BE, CB_CE, CB_DP, CB_RES, CB_USER};
    send_item(OP_READ, 5'd11, '0, '0);
    send_item(OP_MISO, '0, '0, 8'hff);          // miso while idle
    bus_write(5'd1, 32'hffff_ffff);
    bus_write(5'd13, 32'hffff_ffff);            // unmapped
    send_item(OP_READ, 5'd13, '0, '0);
    send_item(OP_NONE, 5'd31, 32'hffff_ffff, 8'hff);
    bus_write(IDX_COMMAND, 32'h0000_0003);      // not one command bit
    bus_write(5'd10, 32'd7);
    for (int i = 0; i < 13; i++) begin
      bus_write(IDX_COMMAND, cmds[i]);
      if (i == 0) bus_write(IDX_COMMAND, CB_WREN);   // command while busy
      finish_xfer();
    end
    // user command with nothing enabled closes at once
    bus_write(5'd6, 32'd0);
    bus_write(5'd8, 32'd0);
    bus_write(IDX_COMMAND, CB_USER);
    send_item(OP_READ, 5'd3, '0, '0);
  endtask

  task automatic random_cmd_seq();
    logic [31:0] cmd_pick [13];
    cmd_pick = '{CB_READ, CB_WREN, CB_WRDI, CB_RDID, CB_RDSR, CB_WRSR, CB_PP,
                 CB_SE, CB_BE, CB_CE, CB_DP, CB_RES, CB_USER};
    case ($urandom_range(9))
      0: bus_write(5'd1, $urandom);
      1: bus_write(5'd1, {8'($urandom_range(6)), 24'($urandom)});
      2: bus_write(5'd7, $urandom);
      3: bus_write(5'd6, $urandom);
      4: bus_write(5'd8, $urandom);
      5: bus_write(5'd9, $urandom_range(130));
      6: bus_write(5'd10, $urandom_range(130));
      7: bus_write(5'd11, $urandom);
      default: ;
    endcase
    bus_write(IDX_COMMAND, ($urandom_range(9) == 0) ? $urandom : cmd_pick[$urandom_range(12)]);
    // mid-transaction noise with bus traffic
    while (cur_phase != PH_IDLE) begin
      case ($urandom_range(9))
        0: send_item(OP_READ, 5'($urandom), $urandom, 8'($urandom));
        1: bus_write(5'($urandom_range(16, 31)), $urandom);
        2: send_item(OP_NONE, 5'($urandom), $urandom, 8'($urandom));
        3: bus_write(IDX_COMMAND, cmd_pick[$urandom_range(12)]);
        default: send_item(OP_MISO, 5'($urandom), $urandom, 8'($urandom));
      endcase
    end
  endtask

  task automatic test_random(int n);
    for (int i = 0; i < n; i++) begin
      if ($urandom_range(3) == 0)
        send_item(2'($urandom), 5'($urandom), $urandom, 8'($urandom));
      else random_cmd_seq();
    end
    finish_xfer();
  endtask

  task automatic test_backpressure();
    hold_cycles = 300;
    for (int i = 0; i < 40; i++) send_item(OP_READ, 5'($urandom), '0, '0);
  endtask

  // result checker
  always @(posedge clk) begin
    flash_result_t got, want;
    if (!rst) begin
      if (out_valid && !out_stall) begin
        got = '{kind, read_data, mosi_byte, cs_lines};
        if (expected_results.size() == 0) begin
          mismatches++;
          if (mismatches <= 10) $display("unexpected result %h", got);
        end else begin
          want = expected_results.pop_front();
          if (got !== want) begin
            mismatches++;
            if (mismatches <= 10)
              $display("result mismatch: kind %0d/%0d data %h/%h mosi %h/%h cs %b/%b",
                       want.kind, got.kind, want.rdata, got.rdata, want.mosi, got.mosi,
                       want.cs, got.cs);
          end
        end
      end
    end
  end

  // receiver: long hold counted here, random idling otherwise
  always @(negedge clk) begin
    if (hold_cycles > 0) hold_cycles <= hold_cycles - 1;
    out_stall <= (hold_cycles > 0) || ($urandom_range(99) < recv_idle_pct);
  end

  // watchdog on idle handshakes
  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall) || hold_cycles > 0)
      quiet_cycles <= 0;
    else if (in_valid || expected_results.size() != 0) begin
      quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= WatchLimit) begin
        $display("SCOREBOARD MISMATCH");
        $finish;
      end
    end
  end

  initial begin
    reset_model();
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);
    send_idle_pct = 30; recv_idle_pct = 66;
    test_directed();
    test_random(24);
    send_idle_pct = 66; recv_idle_pct = 30;
    test_random(24);
    send_idle_pct = 0; recv_idle_pct = 0;
    test_backpressure();
    test_random(24);
    wait_drain();
    repeat (10) @(negedge clk);
    if (mismatches == 0 && expected_results.size() == 0) $display("SCOREBOARD CLEAN");
    else $display("SCOREBOARD MISMATCH");
    $finish;
  end

endmodule
